### rtl/core/pva_pkg.sv
// Shared types and constants of the polyphonic voice allocator.
package pva_pkg;

  localparam int unsigned VoicesDef = 32;
  localparam int unsigned VidxW     = 6;
  localparam int unsigned StampW    = 32;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned VelW      = 7;
  localparam int unsigned PitchW    = 32;
  localparam int unsigned ActW      = 3;
  localparam int unsigned OutIdxW   = 5;

  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_STEAL   = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_FREE    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              hold_f;
    logic [VidxW-1:0]  hold_idx;
    logic              free_f;
    logic [VidxW-1:0]  free_idx;
    logic              rel_f;
    logic [VidxW-1:0]  rel_idx;
    logic [StampW-1:0] rel_age;
    logic              all_f;
    logic [VidxW-1:0]  all_idx;
    logic [StampW-1:0] all_age;
  } scan_t;

  typedef struct packed {
    logic              en;
    logic [VidxW-1:0]  idx;
    logic              busy;
    logic              rel;
    logic [NoteW-1:0]  note;
    logic [StampW-1:0] stamp;
  } wr_t;

endpackage

### rtl/core/pva_if.sv
// Valid/ready channel interfaces for note events and allocation results.
interface pva_evt_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [pva_pkg::NoteW-1:0]  note;
  logic [pva_pkg::VelW-1:0]   velocity;
  logic [pva_pkg::PitchW-1:0] pitch_word;
  logic                       immediate;

  modport source (output valid, op, note, velocity, pitch_word, immediate, input ready);
  modport sink   (input valid, op, note, velocity, pitch_word, immediate, output ready);
endinterface

interface pva_res_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::ActW-1:0]    action;
  logic [pva_pkg::OutIdxW-1:0] voice_index;
  logic [pva_pkg::NoteW-1:0]   out_note;
  logic [pva_pkg::VelW-1:0]    out_velocity;
  logic [pva_pkg::PitchW-1:0]  out_pitch_word;
  logic [pva_pkg::StampW-1:0]  stamp;

  modport source (output valid, action, voice_index, out_note, out_velocity, out_pitch_word,
                  stamp, input ready);
  modport sink   (input valid, action, voice_index, out_note, out_velocity, out_pitch_word,
                  stamp, output ready);
endinterface

### rtl/core/pva_cell.sv
// One voice cell: holds a voice's state and folds it into the passing scan record.
module pva_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pva_pkg::scan_t             scan_i,
  input  logic [pva_pkg::NoteW-1:0]  note_i,
  input  logic [pva_pkg::StampW-1:0] cnt_i,
  input  pva_pkg::wr_t               wr_i,
  output pva_pkg::scan_t             scan_o
);

  localparam logic [pva_pkg::VidxW-1:0] MyIdx = pva_pkg::VidxW'(CellIdx);

  logic                       busy_q;
  logic                       rel_q;
  logic [pva_pkg::NoteW-1:0]  note_q;
  logic [pva_pkg::StampW-1:0] stamp_q;
  logic [pva_pkg::StampW-1:0] age;
  pva_pkg::scan_t             scan_d, scan_q;

  always_comb begin
    age    = cnt_i - stamp_q;
    scan_d = scan_i;
    if (busy_q && (note_q == note_i) && !scan_i.hold_f) begin
      scan_d.hold_f   = 1'b1;
      scan_d.hold_idx = MyIdx;
    end
    if (!busy_q && !scan_i.free_f) begin
      scan_d.free_f   = 1'b1;
      scan_d.free_idx = MyIdx;
    end
    if (rel_q && (!scan_i.rel_f || (age > scan_i.rel_age))) begin
      scan_d.rel_f   = 1'b1;
      scan_d.rel_idx = MyIdx;
      scan_d.rel_age = age;
    end
    if (!scan_i.all_f || (age > scan_i.all_age)) begin
      scan_d.all_f   = 1'b1;
      scan_d.all_idx = MyIdx;
      scan_d.all_age = age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rel_q   <= 1'b0;
      note_q  <= '0;
      stamp_q <= '0;
    end else if (wr_i.en && (wr_i.idx == MyIdx)) begin
      busy_q  <= wr_i.busy;
      rel_q   <= wr_i.rel;
      note_q  <= wr_i.note;
      stamp_q <= wr_i.stamp;
    end
  end

  assign scan_o = scan_q;

endmodule

### rtl/core/poly_voice_allocator_unit.sv
// Voice allocator top level: event control, chain of voice cells, result register.
// Events are taken only in the idle state: each event is scanned and decided before
// the next is taken, the scan record walking the cell chain one voice per cycle;
// a new event is taken while a result waits.
// Reset: all voices free, note and stamp zero, event counter zero, no result pending.
module poly_voice_allocator_unit #(
  parameter int unsigned VOICES = pva_pkg::VoicesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pva_evt_if.sink   evt_i,
  pva_res_if.source res_o
);

  pva_pkg::state_e state_q, state_d;

  logic                       start_q;
  logic [pva_pkg::StampW-1:0] cnt_q;
  logic                       op_q;
  logic [pva_pkg::NoteW-1:0]  note_q;
  logic [pva_pkg::VelW-1:0]   vel_q;
  logic [pva_pkg::PitchW-1:0] pw_q;
  logic                       imm_q;
  pva_pkg::scan_t             res_q;

  logic                        out_valid_q;
  pva_pkg::action_e            act_q, act_d;
  logic [pva_pkg::OutIdxW-1:0] vidx_q;
  logic [pva_pkg::NoteW-1:0]   onote_q, onote_d;
  logic [pva_pkg::VelW-1:0]    ovel_q, ovel_d;
  logic [pva_pkg::PitchW-1:0]  opw_q, opw_d;
  logic [pva_pkg::StampW-1:0]  ostamp_q, ostamp_d;
  logic [pva_pkg::VidxW-1:0]   vsel;

  logic           evt_fire;
  logic           dec_fire;
  pva_pkg::wr_t   wr;
  pva_pkg::scan_t chain [VOICES+1];

  assign evt_fire = evt_i.valid && evt_i.ready;
  assign dec_fire = (state_q == pva_pkg::ST_DECIDE) && (!out_valid_q || res_o.ready);

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start_q;
  end

  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    pva_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .scan_i (chain[g]),
      .note_i (note_q),
      .cnt_i  (cnt_q),
      .wr_i   (wr),
      .scan_o (chain[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pva_pkg::ST_IDLE: begin
        if (evt_fire) state_d = pva_pkg::ST_SCAN;
      end
      pva_pkg::ST_SCAN: begin
        if (chain[VOICES].valid) state_d = pva_pkg::ST_DECIDE;
      end
      pva_pkg::ST_DECIDE: begin
        if (dec_fire) state_d = pva_pkg::ST_IDLE;
      end
      default: state_d = pva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act_d    = pva_pkg::ACT_NONE;
    vsel     = '0;
    onote_d  = '0;
    ovel_d   = '0;
    opw_d    = '0;
    ostamp_d = '0;
    wr       = '0;
    case (pva_pkg::op_e'(op_q))
      pva_pkg::OP_NOTE_ON: begin
        if (res_q.hold_f) begin
          act_d = pva_pkg::ACT_RESTART;
          vsel  = res_q.hold_idx;
        end else if (res_q.free_f) begin
          act_d = pva_pkg::ACT_START;
          vsel  = res_q.free_idx;
          opw_d = pw_q;
        end else begin
          act_d = pva_pkg::ACT_STEAL;
          vsel  = res_q.rel_f ? res_q.rel_idx : res_q.all_idx;
          opw_d = pw_q;
        end
        onote_d  = note_q;
        ovel_d   = vel_q;
        ostamp_d = cnt_q;
        wr.busy  = 1'b1;
        wr.rel   = 1'b0;
      end
      pva_pkg::OP_NOTE_OFF: begin
        if (res_q.hold_f) begin
          vsel     = res_q.hold_idx;
          onote_d  = note_q;
          ostamp_d = cnt_q;
          if (imm_q) begin
            act_d   = pva_pkg::ACT_FREE;
            wr.busy = 1'b0;
            wr.rel  = 1'b0;
          end else begin
            act_d   = pva_pkg::ACT_RELEASE;
            wr.busy = 1'b1;
            wr.rel  = 1'b1;
          end
        end
      end
      default: act_d = pva_pkg::ACT_NONE;
    endcase
    wr.en    = dec_fire && (act_d != pva_pkg::ACT_NONE);
    wr.idx   = vsel;
    wr.note  = note_q;
    wr.stamp = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pva_pkg::ST_IDLE;
      start_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= evt_fire;
      if (evt_fire) cnt_q <= cnt_q + 1'b1;
      if (dec_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_fire) begin
      op_q   <= evt_i.op;
      note_q <= evt_i.note;
      vel_q  <= evt_i.velocity;
      pw_q   <= evt_i.pitch_word;
      imm_q  <= evt_i.immediate;
    end
    if ((state_q == pva_pkg::ST_SCAN) && chain[VOICES].valid) begin
      res_q <= chain[VOICES];
    end
    if (dec_fire) begin
      act_q    <= act_d;
      vidx_q   <= vsel[pva_pkg::OutIdxW-1:0];
      onote_q  <= onote_d;
      ovel_q   <= ovel_d;
      opw_q    <= opw_d;
      ostamp_q <= ostamp_d;
    end
  end

  assign evt_i.ready          = (state_q == pva_pkg::ST_IDLE);
  assign res_o.valid          = out_valid_q;
  assign res_o.action         = act_q;
  assign res_o.voice_index    = vidx_q;
  assign res_o.out_note       = onote_q;
  assign res_o.out_velocity   = ovel_q;
  assign res_o.out_pitch_word = opw_q;
  assign res_o.stamp          = ostamp_q;

endmodule

### verif/tb_poly_voice_allocator_unit.sv
// Randomized and directed testbench for the voice allocator, with a voice-state scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
  pva_pkg::action_e             action;
  logic [pva_pkg::OutIdxW-1:0]  voice_index;
  logic [pva_pkg::NoteW-1:0]    out_note;
  logic [pva_pkg::VelW-1:0]     out_velocity;
  logic [pva_pkg::PitchW-1:0]   out_pitch_word;
  logic [pva_pkg::StampW-1:0]   stamp;
} alloc_res_t;

class voice_alloc_scoreboard;
  bit                         in_use    [pva_pkg::VoicesDef];
  bit                         releasing [pva_pkg::VoicesDef];
  logic [pva_pkg::NoteW-1:0]  note_of   [pva_pkg::VoicesDef];
  logic [pva_pkg::StampW-1:0] stamp_of  [pva_pkg::VoicesDef];
  logic [pva_pkg::StampW-1:0] evt_counter;
  alloc_res_t                 pending_allocs[$];
  int unsigned                errors;

  function new();
    for (int i = 0; i < pva_pkg::VoicesDef; i++) begin
      in_use[i]    = 1'b0;
      releasing[i] = 1'b0;
      note_of[i]   = '0;
      stamp_of[i]  = '0;
    end
    evt_counter = '0;
    errors      = 0;
  endfunction

  function int holder_of(logic [pva_pkg::NoteW-1:0] note);
    for (int i = 0; i < pva_pkg::VoicesDef; i++) begin
      if (in_use[i] && note_of[i] == note) return i;
    end
    return -1;
  endfunction

  function void note_event(pva_pkg::op_e op, logic [pva_pkg::NoteW-1:0] note,
                           logic [pva_pkg::VelW-1:0] vel,
                           logic [pva_pkg::PitchW-1:0] pw, logic imm);
    alloc_res_t                 r;
    int                         v;
    int                         rel_idx;
    int                         all_idx;
    logic [pva_pkg::StampW-1:0] age;
    logic [pva_pkg::StampW-1:0] rel_age;
    logic [pva_pkg::StampW-1:0] all_age;
    r           = '0;
    r.action    = pva_pkg::ACT_NONE;
    evt_counter = evt_counter + 1;
    v           = holder_of(note);
    if (op == pva_pkg::OP_NOTE_ON) begin
      if (v >= 0) begin
        r.action = pva_pkg::ACT_RESTART;
      end else begin
        for (int i = 0; i < pva_pkg::VoicesDef; i++) begin
          if (!in_use[i] && v < 0) v = i;
        end
        if (v >= 0) begin
          r.action = pva_pkg::ACT_START;
        end else begin
          rel_idx = -1;
          all_idx = -1;
          rel_age = '0;
          all_age = '0;
          for (int i = 0; i < pva_pkg::VoicesDef; i++) begin
            age = evt_counter - stamp_of[i];
            if (releasing[i] && (rel_idx < 0 || age > rel_age)) begin
              rel_idx = i;
              rel_age = age;
            end
            if (all_idx < 0 || age > all_age) begin
              all_idx = i;
              all_age = age;
            end
          end
          v        = (rel_idx >= 0) ? rel_idx : all_idx;
          r.action = pva_pkg::ACT_STEAL;
        end
        r.out_pitch_word = pw;
      end
      in_use[v]      = 1'b1;
      note_of[v]     = note;
      releasing[v]   = 1'b0;
      stamp_of[v]    = evt_counter;
      r.out_note     = note;
      r.out_velocity = vel;
      r.stamp        = evt_counter;
    end else if (v >= 0) begin
      if (imm) begin
        r.action     = pva_pkg::ACT_FREE;
        in_use[v]    = 1'b0;
        releasing[v] = 1'b0;
      end else begin
        r.action     = pva_pkg::ACT_RELEASE;
        releasing[v] = 1'b1;
      end
      stamp_of[v] = evt_counter;
      r.out_note  = note_of[v];
      r.stamp     = evt_counter;
    end else begin
      v = 0;
    end
    r.voice_index = v[pva_pkg::OutIdxW-1:0];
    pending_allocs.push_back(r);
  endfunction

  function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(alloc_res_t got);
    alloc_res_t want;
    if (pending_allocs.size() == 0) begin
      $error("result with no event outstanding: action %0d voice %0d", got.action,
             got.voice_index);
      errors++;
      return;
    end
    want = pending_allocs.pop_front();
    cmp_field("action", 32'(want.action), 32'(got.action));
    cmp_field("voice_index", 32'(want.voice_index), 32'(got.voice_index));
    cmp_field("out_note", 32'(want.out_note), 32'(got.out_note));
    cmp_field("out_velocity", 32'(want.out_velocity), 32'(got.out_velocity));
    cmp_field("out_pitch_word", want.out_pitch_word, got.out_pitch_word);
    cmp_field("stamp", want.stamp, got.stamp);
  endfunction

  function int pending();
    return pending_allocs.size();
  endfunction
endclass

module tb_poly_voice_allocator_unit;

  localparam int unsigned VOICES     = pva_pkg::VoicesDef;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned MAX_CYCLES = 2000000;

  logic        clk_i;
  logic        rst_ni;
  int          hold_token;
  int unsigned cycles;

  voice_alloc_scoreboard alloc_sb = new();

  pva_evt_if evt ();
  pva_res_if res ();

  poly_voice_allocator_unit #(
    .VOICES(VOICES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .evt_i (evt),
    .res_o (res)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    alloc_res_t got;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got.action         = pva_pkg::action_e'(res.action);
        got.voice_index    = res.voice_index;
        got.out_note       = res.out_note;
        got.out_velocity   = res.out_velocity;
        got.out_pitch_word = res.out_pitch_word;
        got.stamp          = res.stamp;
        alloc_sb.check_result(got);
      end
      if (evt.valid && evt.ready) begin
        alloc_sb.note_event(pva_pkg::op_e'(evt.op), evt.note, evt.velocity, evt.pitch_word,
                            evt.immediate);
      end
    end
  end

  initial begin : result_sink
    int seen_hold;
    int stall_pct;
    seen_hold = 0;
    stall_pct = 20;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          2:       stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      if (hold_token != seen_hold) begin
        seen_hold = hold_token;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < stall_pct) begin
        res.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  task automatic send_event(pva_pkg::op_e op, logic [pva_pkg::NoteW-1:0] note,
                            logic [pva_pkg::VelW-1:0] vel,
                            logic [pva_pkg::PitchW-1:0] pw, logic imm);
    evt.valid      <= 1'b1;
    evt.op         <= op;
    evt.note       <= note;
    evt.velocity   <= vel;
    evt.pitch_word <= pw;
    evt.immediate  <= imm;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
  endtask

  task automatic pause_events(int n);
    evt.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    evt.valid <= 1'b0;
    do @(posedge clk_i); while (alloc_sb.pending() != 0);
  endtask

  initial begin : stimulus
    int                        on_pct;
    int                        idle_pct;
    int                        imm_pct;
    int                        win_lo;
    int                        win_w;
    pva_pkg::op_e              op;
    logic [pva_pkg::NoteW-1:0] nt;
    logic                      imm;
    hold_token = 0;
    rst_ni         <= 1'b0;
    evt.valid      <= 1'b0;
    evt.op         <= pva_pkg::OP_NOTE_ON;
    evt.note       <= '0;
    evt.velocity   <= '0;
    evt.pitch_word <= '0;
    evt.immediate  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(pva_pkg::OP_NOTE_ON, 7'd0, 7'd0, 32'h0000_0000, 1'b0);
    send_event(pva_pkg::OP_NOTE_ON, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1);
    pause_events(gap_len());
    send_event(pva_pkg::OP_NOTE_ON, 7'd0, 7'd64, 32'h1234_5678, 1'b0);
    send_event(pva_pkg::OP_NOTE_OFF, 7'd5, 7'd33, 32'hDEAD_BEEF, 1'b0);
    send_event(pva_pkg::OP_NOTE_OFF, 7'd5, 7'd0, 32'h0, 1'b1);
    send_event(pva_pkg::OP_NOTE_OFF, 7'd127, 7'd0, 32'h0, 1'b0);
    pause_events(gap_len());
    send_event(pva_pkg::OP_NOTE_OFF, 7'd127, 7'd0, 32'h0, 1'b0);
    send_event(pva_pkg::OP_NOTE_ON, 7'd127, 7'd1, 32'hAAAA_5555, 1'b0);
    send_event(pva_pkg::OP_NOTE_OFF, 7'd0, 7'd127, 32'h5555_AAAA, 1'b1);
    send_event(pva_pkg::OP_NOTE_OFF, 7'd0, 7'd0, 32'h0, 1'b0);
    send_event(pva_pkg::OP_NOTE_ON, 7'd85, 7'd42, 32'h8000_0001, 1'b0);
    send_event(pva_pkg::OP_NOTE_OFF, 7'd85, 7'd0, 32'h0, 1'b1);
    drain_results();

    for (int blk = 0; blk < 20; blk++) begin
      case ($urandom_range(0, 2))
        0:       on_pct = 85;
        1:       on_pct = 60;
        default: on_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       win_w = 16;
        1:       win_w = 40;
        default: win_w = 64;
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      imm_pct = $urandom_range(0, 1) ? 10 : 50;
      win_lo  = $urandom_range(0, 128 - win_w);
      if (blk == 2) begin
        idle_pct = 0;
        hold_token++;
      end
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          op  = pva_pkg::op_e'($urandom_range(0, 1));
          nt  = 7'($urandom_range(0, 127));
          imm = 1'($urandom_range(0, 1));
        end else begin
          op  = ($urandom_range(0, 99) < on_pct) ? pva_pkg::OP_NOTE_ON : pva_pkg::OP_NOTE_OFF;
          nt  = 7'(win_lo + $urandom_range(0, win_w - 1));
          imm = ($urandom_range(0, 99) < imm_pct);
        end
        send_event(op, nt, 7'($urandom_range(0, 127)), $urandom, imm);
        if ($urandom_range(0, 99) < idle_pct) pause_events(gap_len());
      end
      if (blk % 5 == 4) drain_results();
    end

    drain_results();
    repeat (VOICES + 8) @(posedge clk_i);
    if (alloc_sb.errors == 0 && alloc_sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
